// ===== rtl/round_robin_interval_task_scheduler_core_defines.svh =====
// Assertion macros for the task scheduler core.
`ifndef ROUND_ROBIN_INTERVAL_TASK_SCHEDULER_CORE_DEFINES_SVH
`define ROUND_ROBIN_INTERVAL_TASK_SCHEDULER_CORE_DEFINES_SVH

// Property checked on every clock edge outside reset.
`define RRTS_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked on every clock edge, reset included.
`define RRTS_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/rrts_pkg.sv =====
// Types and constants for the task scheduler core.
`timescale 1ns / 1ps
package rrts_pkg;

  localparam int unsigned IdW   = 32;
  localparam int unsigned TimeW = 27;
  localparam int unsigned CmdW  = 3;
  localparam int unsigned StW   = 3;

  typedef enum logic [CmdW-1:0] {
    CMD_RUN        = 3'd0,
    CMD_RUN_FORCED = 3'd1,
    CMD_RUN_SINGLE = 3'd2,
    CMD_ADD        = 3'd3,
    CMD_DELETE     = 3'd4,
    CMD_SET_ACTIVE = 3'd5,
    CMD_SET_IVL    = 3'd6,
    CMD_UNUSED     = 3'd7
  } cmd_t;

  typedef enum logic [StW-1:0] {
    ST_OK        = 3'd0,
    ST_NOT_FOUND = 3'd1,
    ST_FULL      = 3'd2,
    ST_NONE      = 3'd3,
    ST_DISABLED  = 3'd4
  } status_t;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_FIND  = 7'b0000010,
    S_SCAN  = 7'b0000100,
    S_SHIFT = 7'b0001000,
    S_VISIT = 7'b0010000,
    S_WRITE = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

endpackage

// ===== rtl/round_robin_interval_task_scheduler_core.sv =====
// Top level of the round-robin interval task scheduler.
//
// channel | ports        | dir | payload
// --------+--------------+-----+----------------------------------------------
// in      | in_t*        | in  | command, task_id, interval_ms, active_flag,
//         |              |     | now_ms, cursor_reset
// out     | out_t*       | out | status, result_id, fired, old_interval,
//         |              |     | old_active
// cfg     | cfg_we/wdata | in  | enabled
//
// One item at a time. Lookups walk the table one entry per cycle through a
// single ID comparator; delete then shifts each later entry down one place;
// an add whose ID counter wraps rescans the table for a free ID.
// Reset clears counts, cursor, counter and enable; table contents are kept.
// A pending result stalls the input side until out_tready takes it.
`timescale 1ns / 1ps
`include "round_robin_interval_task_scheduler_core_defines.svh"
module round_robin_interval_task_scheduler_core
  import rrts_pkg::*;
#(
  parameter int unsigned MAX_TASKS = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // [2:0] command, [34:3] task_id, [61:35] interval_ms, [62] active_flag,
  // [89:63] now_ms, [90] cursor_reset, [95:91] zero
  input  logic [95:0]  in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // [2:0] status, [34:3] result_id, [35] fired, [62:36] old_interval,
  // [63] old_active
  output logic [63:0]  out_tdata,
  input  logic         cfg_we,
  input  logic         cfg_wdata
);

  localparam int unsigned IW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int unsigned CW = $clog2(MAX_TASKS + 1);

  logic [IdW-1:0]   mem_id   [MAX_TASKS];
  logic [TimeW-1:0] mem_ivl  [MAX_TASKS];
  logic [TimeW-1:0] mem_last [MAX_TASKS];
  logic             mem_act  [MAX_TASKS];

  state_t state_r, state_nxt;
  logic [CW-1:0]    count_r, count_nxt, cursor_r, cursor_nxt, idx_r, idx_nxt;
  logic [IdW-1:0]   ctr_r, ctr_nxt, cand_r, cand_nxt;
  logic             en_r;
  cmd_t             cmd_r;
  logic [IdW-1:0]   tid_r;
  logic [TimeW-1:0] ivl_r, now_r;
  logic             act_r;
  logic [CW-1:0]    slot_r, slot_nxt;

  status_t          o_st_r, o_st_nxt;
  logic [IdW-1:0]   o_id_r, o_id_nxt;
  logic             o_fire_r, o_fire_nxt;
  logic [TimeW-1:0] o_oivl_r, o_oivl_nxt;
  logic             o_oact_r, o_oact_nxt;

  // shared read port
  logic [IW-1:0]    rd_a;
  logic [IdW-1:0]   rd_id;
  logic [TimeW-1:0] rd_ivl, rd_last, last_eff;
  logic             rd_act, id_hit;

  // single write port
  logic             wr_en;
  logic [IW-1:0]    wr_a;
  logic [IdW-1:0]   wr_id;
  logic [TimeW-1:0] wr_ivl, wr_last;
  logic             wr_act;

  assign rd_a    = idx_r[IW-1:0];
  assign rd_id   = mem_id[rd_a];
  assign rd_ivl  = mem_ivl[rd_a];
  assign rd_last = mem_last[rd_a];
  assign rd_act  = mem_act[rd_a];
  assign id_hit  = (rd_id == (cmd_r == CMD_ADD ? cand_r : tid_r));
  assign last_eff = (rd_last == '0 || now_r < rd_last) ? now_r : rd_last;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = (state_r == S_OUT);
  assign out_tdata  = {o_oact_r, o_oivl_r, o_fire_r, o_id_r, o_st_r};

  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    cursor_nxt = cursor_r;
    idx_nxt    = idx_r;
    ctr_nxt    = ctr_r;
    cand_nxt   = cand_r;
    slot_nxt   = slot_r;
    o_st_nxt   = o_st_r;
    o_id_nxt   = o_id_r;
    o_fire_nxt = o_fire_r;
    o_oivl_nxt = o_oivl_r;
    o_oact_nxt = o_oact_r;
    wr_en   = 1'b0;
    wr_a    = rd_a;
    wr_id   = rd_id;
    wr_ivl  = rd_ivl;
    wr_last = rd_last;
    wr_act  = rd_act;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          o_st_nxt   = ST_OK;
          o_id_nxt   = '0;
          o_fire_nxt = 1'b0;
          o_oivl_nxt = '0;
          o_oact_nxt = 1'b0;
          idx_nxt    = '0;
          state_nxt  = S_OUT;
          unique case (cmd_t'(in_tdata[2:0]))
            CMD_RUN, CMD_RUN_FORCED: begin
              if (in_tdata[2:0] == CMD_RUN && !en_r) begin
                o_st_nxt = ST_DISABLED;
              end else if (cursor_r < count_r) begin
                idx_nxt   = cursor_r;
                state_nxt = S_VISIT;
              end else begin
                o_st_nxt = ST_NONE;
                if (count_r != '0) cursor_nxt = '0;
              end
            end
            CMD_ADD: begin
              if (count_r >= CW'(MAX_TASKS)) begin
                o_st_nxt = ST_FULL;
              end else if (count_r == '0) begin
                cand_nxt  = IdW'(1);
                ctr_nxt   = IdW'(1);
                state_nxt = S_WRITE;
              end else begin
                cand_nxt  = ctr_r + IdW'(1);
                ctr_nxt   = ctr_r + IdW'(1);
                state_nxt = (ctr_r + IdW'(1) == '0) ? S_SCAN : S_WRITE;
              end
            end
            CMD_SET_IVL: begin
              if (in_tdata[90]) begin
                if (cursor_r >= count_r) cursor_nxt = '0;
              end else begin
                state_nxt = S_FIND;
              end
            end
            CMD_UNUSED: o_st_nxt = ST_NONE;
            default: state_nxt = S_FIND;
          endcase
        end
      end
      S_FIND: begin
        if (idx_r >= count_r) begin
          o_st_nxt  = ST_NOT_FOUND;
          state_nxt = S_OUT;
        end else if (id_hit) begin
          o_id_nxt  = tid_r;
          state_nxt = S_OUT;
          unique case (cmd_r)
            CMD_RUN_SINGLE: o_fire_nxt = 1'b1;
            CMD_SET_ACTIVE: begin
              o_oact_nxt = rd_act;
              wr_en  = 1'b1;
              wr_act = act_r;
            end
            CMD_SET_IVL: begin
              o_oivl_nxt = rd_ivl;
              wr_en  = 1'b1;
              wr_ivl = ivl_r;
            end
            CMD_DELETE: begin
              slot_nxt  = idx_r;
              state_nxt = S_SHIFT;
            end
            default: ;
          endcase
        end else begin
          idx_nxt = idx_r + CW'(1);
        end
      end
      S_SHIFT: begin
        // idx_r points at the entry to move down one place
        if (slot_r + CW'(1) >= count_r) begin
          count_nxt = count_r - CW'(1);
          state_nxt = S_OUT;
        end else begin
          idx_nxt = slot_r + CW'(1);
          if (idx_r == slot_r + CW'(1)) begin
            wr_en = 1'b1;
            wr_a  = slot_r[IW-1:0];
            slot_nxt = slot_r + CW'(1);
          end
        end
      end
      S_SCAN: begin
        if (idx_r >= count_r) begin
          state_nxt = S_WRITE;
        end else if (id_hit) begin
          cand_nxt = cand_r + IdW'(1);
          idx_nxt  = '0;
        end else begin
          idx_nxt = idx_r + CW'(1);
          if (ctr_r < cand_r) ctr_nxt = cand_r;
        end
      end
      S_WRITE: begin
        wr_en   = 1'b1;
        wr_a    = count_r[IW-1:0];
        wr_id   = cand_r;
        wr_ivl  = ivl_r;
        wr_last = now_r;
        wr_act  = act_r;
        count_nxt = count_r + CW'(1);
        o_id_nxt  = cand_r;
        state_nxt = S_OUT;
      end
      S_VISIT: begin
        wr_en   = 1'b1;
        wr_last = last_eff;
        if (rd_act && (rd_ivl == '0 || (now_r - last_eff) >= rd_ivl)) begin
          o_fire_nxt = 1'b1;
          wr_last    = now_r;
        end
        o_id_nxt   = rd_id;
        cursor_nxt = cursor_r + CW'(1);
        state_nxt  = S_OUT;
      end
      S_OUT: begin
        if (out_tready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_id[wr_a]   <= wr_id;
      mem_ivl[wr_a]  <= wr_ivl;
      mem_last[wr_a] <= wr_last;
      mem_act[wr_a]  <= wr_act;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      count_r  <= '0;
      cursor_r <= '0;
      ctr_r    <= '0;
      en_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      cursor_r <= cursor_nxt;
      ctr_r    <= ctr_nxt;
      if (cfg_we) en_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    idx_r    <= idx_nxt;
    cand_r   <= cand_nxt;
    slot_r   <= slot_nxt;
    o_st_r   <= o_st_nxt;
    o_id_r   <= o_id_nxt;
    o_fire_r <= o_fire_nxt;
    o_oivl_r <= o_oivl_nxt;
    o_oact_r <= o_oact_nxt;
    if (in_tvalid && in_tready) begin
      cmd_r  <= cmd_t'(in_tdata[2:0]);
      tid_r  <= in_tdata[34:3];
      ivl_r  <= in_tdata[61:35];
      act_r  <= in_tdata[62];
      now_r  <= in_tdata[89:63];
    end
  end

  `RRTS_ASSERT(a_count_max, clk, rst_n, count_r <= CW'(MAX_TASKS), "entry count over capacity")
  `RRTS_ASSERT(a_ready_out, clk, rst_n, !(in_tready && out_tvalid), "ready while result pending")
  `RRTS_ASSERT(a_add_grow, clk, rst_n, (state_r == S_WRITE) |=> (count_r == $past(count_r) + CW'(1)), "add did not grow table")
  `RRTS_ASSERT(a_state_hot, clk, rst_n, $onehot(state_r), "state not one-hot")

endmodule

// ===== sim/round_robin_interval_task_scheduler_core_tb.sv =====
// Self-checking testbench for the round-robin interval task scheduler core.
`timescale 1ns / 1ps
module round_robin_interval_task_scheduler_core_tb;
  import rrts_pkg::*;

  localparam int NTASK = 16;
  localparam logic [26:0] DAY_MS = 27'd86400000;
  localparam int IDLE_LIMIT = 4000;
  localparam int RAND_ITEMS = 1130;

  typedef struct packed {
    cmd_t        cmd;
    logic [31:0] tid;
    logic [26:0] ivl;
    logic        act;
    logic [26:0] now;
    logic        crst;
  } sched_cmd_t;

  typedef struct packed {
    status_t     st;
    logic [31:0] rid;
    logic        fired;
    logic [26:0] old_ivl;
    logic        old_act;
  } sched_rsp_t;

  typedef struct packed {
    sched_cmd_t  c;
    logic        typed;
    status_t     st;
    logic [31:0] rid;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [95:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;
  logic        cfg_we = 1'b0;
  logic        cfg_wdata = 1'b0;

  // scheduler shadow
  logic [31:0] sh_id [NTASK];
  logic [26:0] sh_ivl [NTASK];
  logic [26:0] sh_last [NTASK];
  logic        sh_act [NTASK];
  int          sh_count = 0;
  int          sh_cursor = 0;
  logic [31:0] sh_ctr = '0;
  logic        sh_en = 1'b0;

  sched_rsp_t  rsp_pending [$];
  int          errs = 0;
  int          n_rsp = 0;
  int          n_fired = 0;
  int          n_full = 0;
  int          idle_cnt = 0;
  logic [26:0] clock_ms = '0;

  always #2 clk = ~clk;

  round_robin_interval_task_scheduler_core #(.MAX_TASKS(NTASK)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  function automatic int find_task(logic [31:0] id);
    for (int i = 0; i < sh_count; i++) if (sh_id[i] == id) return i;
    return -1;
  endfunction

  function automatic void visit_task(logic [26:0] now, ref sched_rsp_t r);
    int k;
    if (sh_cursor < sh_count) begin
      k = sh_cursor;
      if (sh_last[k] == 0 || now < sh_last[k]) sh_last[k] = now;
      if (sh_act[k] && (sh_ivl[k] == 0 || now - sh_last[k] >= sh_ivl[k])) begin
        r.fired = 1'b1;
        sh_last[k] = now;
      end
      r.rid = sh_id[k];
      sh_cursor++;
    end else begin
      if (sh_count != 0) sh_cursor = 0;
      r.st = ST_NONE;
    end
  endfunction

  function automatic sched_rsp_t schedule_step(sched_cmd_t c);
    sched_rsp_t r;
    int k, i;
    logic [31:0] id;
    r = '{st: ST_OK, rid: '0, fired: 1'b0, old_ivl: '0, old_act: 1'b0};
    case (c.cmd)
      CMD_RUN: begin
        if (!sh_en) r.st = ST_DISABLED;
        else visit_task(c.now, r);
      end
      CMD_RUN_FORCED: visit_task(c.now, r);
      CMD_RUN_SINGLE: begin
        if (find_task(c.tid) >= 0) begin
          r.rid = c.tid;
          r.fired = 1'b1;
        end else r.st = ST_NOT_FOUND;
      end
      CMD_ADD: begin
        if (sh_count >= NTASK) r.st = ST_FULL;
        else begin
          if (sh_count == 0) begin
            id = 32'd1;
            sh_ctr = 32'd1;
          end else begin
            sh_ctr = sh_ctr + 32'd1;
            id = sh_ctr;
            if (id == 0) begin
              i = 0;
              while (i < sh_count) begin
                if (sh_id[i] == id) begin
                  id = id + 32'd1;
                  i = 0;
                end else begin
                  i++;
                  if (sh_ctr < id) sh_ctr = id;
                end
              end
            end
          end
          sh_id[sh_count] = id;
          sh_ivl[sh_count] = c.ivl;
          sh_last[sh_count] = c.now;
          sh_act[sh_count] = c.act;
          sh_count++;
          r.rid = id;
        end
      end
      CMD_DELETE: begin
        k = find_task(c.tid);
        if (k >= 0) begin
          for (i = k; i + 1 < sh_count; i++) begin
            sh_id[i] = sh_id[i+1];
            sh_ivl[i] = sh_ivl[i+1];
            sh_last[i] = sh_last[i+1];
            sh_act[i] = sh_act[i+1];
          end
          sh_count--;
          r.rid = c.tid;
        end else r.st = ST_NOT_FOUND;
      end
      CMD_SET_ACTIVE: begin
        k = find_task(c.tid);
        if (k >= 0) begin
          r.old_act = sh_act[k];
          sh_act[k] = c.act;
          r.rid = c.tid;
        end else r.st = ST_NOT_FOUND;
      end
      CMD_SET_IVL: begin
        if (c.crst) begin
          if (sh_cursor >= sh_count) sh_cursor = 0;
        end else begin
          k = find_task(c.tid);
          if (k >= 0) begin
            r.old_ivl = sh_ivl[k];
            sh_ivl[k] = c.ivl;
            r.rid = c.tid;
          end else r.st = ST_NOT_FOUND;
        end
      end
      default: r.st = ST_NONE;
    endcase
    return r;
  endfunction

  function automatic logic [26:0] draw_interval();
    int p;
    p = $urandom_range(0, 99);
    if (p < 60) return 27'($urandom_range(1, 5000));
    if (p < 75) return '0;
    if (p < 90) return 27'($urandom_range(0, 86400000));
    return DAY_MS;
  endfunction

  function automatic logic [31:0] draw_id();
    if (sh_count > 0 && $urandom_range(0, 99) < 80)
      return sh_id[$urandom_range(0, sh_count - 1)];
    if ($urandom_range(0, 1)) return $urandom();
    return 32'($urandom_range(0, 40));
  endfunction

  function automatic sched_cmd_t draw_cmd();
    sched_cmd_t c;
    int p;
    p = $urandom_range(0, 99);
    if (p < 20) c.cmd = CMD_RUN;
    else if (p < 38) c.cmd = CMD_RUN_FORCED;
    else if (p < 46) c.cmd = CMD_RUN_SINGLE;
    else if (p < 66) c.cmd = CMD_ADD;
    else if (p < 78) c.cmd = CMD_DELETE;
    else if (p < 86) c.cmd = CMD_SET_ACTIVE;
    else if (p < 97) c.cmd = CMD_SET_IVL;
    else c.cmd = CMD_UNUSED;
    c.tid = draw_id();
    c.ivl = draw_interval();
    c.act = ($urandom_range(0, 99) < 75);
    c.crst = (c.cmd == CMD_SET_IVL) ? ($urandom_range(0, 2) == 0) : 1'($urandom());
    // wall clock mostly moves forward and wraps at midnight
    p = $urandom_range(0, 99);
    if (p < 3) clock_ms = '0;
    else if (p < 8) clock_ms = 27'($urandom_range(0, 86399999));
    else begin
      clock_ms = clock_ms + 27'($urandom_range(0, 3000));
      if (clock_ms >= DAY_MS) clock_ms = clock_ms - DAY_MS;
    end
    c.now = clock_ms;
    return c;
  endfunction

  task automatic send_cmd(sched_cmd_t c, logic typed, status_t st, logic [31:0] rid, int gap);
    sched_rsp_t r;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {5'b0, c.crst, c.now, c.act, c.ivl, c.tid, c.cmd};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    r = schedule_step(c);
    if (r.st == ST_FULL) n_full++;
    if (typed) begin
      r.st = st;
      r.rid = rid;
    end
    rsp_pending.push_back(r);
  endtask

  task automatic write_enable(logic v);
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (rsp_pending.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sh_en = v;
  endtask

  // receiver with random stalls and one long hold-off
  initial begin
    int g;
    bit held;
    held = 0;
    @(posedge rst_n);
    forever begin
      g = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
      if (!held && n_rsp >= 400) begin
        held = 1;
        g = 200;
      end
      if (g > 0) begin
        out_tready <= 1'b0;
        repeat (g) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
    end
  end

  // result check
  always @(posedge clk) begin
    sched_rsp_t e;
    if (rst_n && out_tvalid && out_tready) begin
      n_rsp <= n_rsp + 1;
      if (out_tdata[35]) n_fired <= n_fired + 1;
      if (rsp_pending.size() == 0) begin
        $error("unexpected result %h", out_tdata);
        errs = errs + 1;
      end else begin
        e = rsp_pending.pop_front();
        if (out_tdata[2:0] !== e.st) begin
          $error("status exp %0d got %0d", e.st, out_tdata[2:0]); errs = errs + 1;
        end
        if (out_tdata[34:3] !== e.rid) begin
          $error("result_id exp %0h got %0h", e.rid, out_tdata[34:3]); errs = errs + 1;
        end
        if (out_tdata[35] !== e.fired) begin
          $error("fired exp %0b got %0b", e.fired, out_tdata[35]); errs = errs + 1;
        end
        if (out_tdata[62:36] !== e.old_ivl) begin
          $error("old_interval exp %0d got %0d", e.old_ivl, out_tdata[62:36]);
          errs = errs + 1;
        end
        if (out_tdata[63] !== e.old_act) begin
          $error("old_active exp %0b got %0b", e.old_act, out_tdata[63]); errs = errs + 1;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n) idle_cnt <= 0;
    else idle_cnt <= idle_cnt + 1;
    if (idle_cnt >= IDLE_LIMIT) begin
      $display("** round_robin_interval_task_scheduler_core: FAILED **");
      $finish;
    end
  end

  dir_row_t dir_tbl [20] = '{
    '{'{CMD_RUN,        32'd0,        27'd0,     1'b0, 27'd0,        1'b0}, 1'b1, ST_DISABLED,  32'd0},
    '{'{CMD_RUN_FORCED, 32'd0,        27'd0,     1'b0, 27'd0,        1'b0}, 1'b1, ST_NONE,      32'd0},
    '{'{CMD_RUN_SINGLE, 32'd5,        27'd0,     1'b0, 27'd0,        1'b0}, 1'b1, ST_NOT_FOUND, 32'd0},
    '{'{CMD_DELETE,     32'd0,        27'd0,     1'b0, 27'd0,        1'b0}, 1'b1, ST_NOT_FOUND, 32'd0},
    '{'{CMD_SET_ACTIVE, 32'hFFFFFFFF, 27'd0,     1'b1, 27'd0,        1'b0}, 1'b1, ST_NOT_FOUND, 32'd0},
    '{'{CMD_SET_IVL,    32'd1,        27'd5,     1'b0, 27'd0,        1'b0}, 1'b1, ST_NOT_FOUND, 32'd0},
    '{'{CMD_SET_IVL,    32'd0,        27'd0,     1'b0, 27'd0,        1'b1}, 1'b1, ST_OK,        32'd0},
    '{'{CMD_UNUSED,     32'hFFFFFFFF, DAY_MS,    1'b1, 27'd86399999, 1'b1}, 1'b1, ST_NONE,      32'd0},
    '{'{CMD_ADD,        32'd0,        27'd0,     1'b1, 27'd0,        1'b0}, 1'b1, ST_OK,        32'd1},
    '{'{CMD_ADD,        32'd0,        DAY_MS,    1'b1, 27'd86399999, 1'b0}, 1'b1, ST_OK,        32'd2},
    '{'{CMD_ADD,        32'd0,        27'd1000,  1'b0, 27'd500,      1'b0}, 1'b1, ST_OK,        32'd3},
    '{'{CMD_RUN_FORCED, 32'd0,        27'd0,     1'b0, 27'd1000,     1'b0}, 1'b0, ST_OK,        32'd0},
    '{'{CMD_RUN_FORCED, 32'd0,        27'd0,     1'b0, 27'd0,        1'b0}, 1'b0, ST_OK,        32'd0},
    '{'{CMD_RUN_FORCED, 32'd0,        27'd0,     1'b0, 27'd2000,     1'b0}, 1'b0, ST_OK,        32'd0},
    '{'{CMD_RUN_FORCED, 32'd0,        27'd0,     1'b0, 27'd2500,     1'b0}, 1'b1, ST_NONE,      32'd0},
    '{'{CMD_SET_ACTIVE, 32'd3,        27'd0,     1'b1, 27'd0,        1'b0}, 1'b0, ST_OK,        32'd0},
    '{'{CMD_SET_IVL,    32'd2,        27'd0,     1'b0, 27'd0,        1'b0}, 1'b0, ST_OK,        32'd0},
    '{'{CMD_RUN_SINGLE, 32'd3,        27'd0,     1'b0, 27'd0,        1'b0}, 1'b0, ST_OK,        32'd0},
    '{'{CMD_DELETE,     32'd1,        27'd0,     1'b0, 27'd0,        1'b0}, 1'b1, ST_OK,        32'd1},
    '{'{CMD_SET_IVL,    32'd0,        27'd0,     1'b0, 27'd0,        1'b1}, 1'b0, ST_OK,        32'd0}
  };

  initial begin
    bit fast;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_enable(1'b0);
    foreach (dir_tbl[i])
      send_cmd(dir_tbl[i].c, dir_tbl[i].typed, dir_tbl[i].st, dir_tbl[i].rid,
               $urandom_range(0, 7));
    fast = 0;
    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n % (RAND_ITEMS / 4) == 0) write_enable(n % (2 * (RAND_ITEMS / 4)) == 0);
      if (n % 60 == 0) fast = ($urandom_range(0, 3) == 0);
      send_cmd(draw_cmd(), 1'b0, ST_OK, '0, fast ? 0 : $urandom_range(0, 7));
    end
    write_enable(1'b1);
    in_tvalid <= 1'b0;
    while (rsp_pending.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    $display("Covered %0d results, %0d tasks fired, %0d adds refused on a full table,",
             n_rsp, n_fired, n_full);
    $display("with the enable toggled across phases and a long output hold-off.");
    if (errs == 0) $display("** round_robin_interval_task_scheduler_core: PASSED **");
    else $display("** round_robin_interval_task_scheduler_core: FAILED **");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/rrts_pkg.sv
rtl/round_robin_interval_task_scheduler_core.sv
sim/round_robin_interval_task_scheduler_core_tb.sv
